### sv/scfc_pkg.sv
// Shared types, constants and the CRC-8 step for the sync/CRC-8 frame checker.
// No dependencies; every other file uses this package by scoped names.
`default_nettype none

package scfc_pkg;

  localparam int PAYLOAD_BYTES = 24;
  localparam int FRAME_LEN     = PAYLOAD_BYTES + 5;
  localparam int IDX_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int COUNT_W       = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'd127;
  localparam logic [COUNT_W-1:0] IDX_SYNC0  = 7'd0;
  localparam logic [COUNT_W-1:0] IDX_SYNC1  = 7'd1;
  localparam logic [COUNT_W-1:0] IDX_TYPE   = 7'd2;
  localparam logic [COUNT_W-1:0] IDX_SEQ    = 7'd3;
  localparam logic [COUNT_W-1:0] IDX_PL0    = 7'd4;
  localparam logic [COUNT_W-1:0] IDX_CRC    = COUNT_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0]   PL_LAST    = IDX_W'(PAYLOAD_BYTES - 1);

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd170;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd85;

  // configuration register indexes
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_SYN = 2'd2,
    ST_BAD_CRC = 2'd3
  } status_t;

  // one classified frame, front to back
  typedef struct packed {
    status_t    status;
    logic [7:0] msg_type;
    logic [7:0] seq;
    logic       bank;
  } job_t;

  // payload store write port, front to back
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } memwr_t;

  // MSB-first CRC-8, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/scfc_front.sv
// Front end: takes frame bytes, tracks count/sync/CRC, writes payload bytes
// and pushes one classified job per flagged byte. Uses scfc_pkg.
`default_nettype none

module scfc_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 last_byte,
  input  wire logic                 q_full,
  output logic                      push,
  output scfc_pkg::job_t            push_job,
  output scfc_pkg::memwr_t          memwr
);

  logic [7:0]                   sync_first;
  logic [7:0]                   sync_second;
  logic [scfc_pkg::COUNT_W-1:0] byte_count;
  logic [7:0]                   running_crc;
  logic                         sync_match;
  logic [7:0]                   type_hold;
  logic [7:0]                   sequence_hold;
  logic                         wr_bank;

  logic                         accept;
  logic                         in_body;
  logic                         crc_ok;
  scfc_pkg::status_t            status;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign in_body  = (byte_count >= scfc_pkg::IDX_TYPE) && (byte_count < scfc_pkg::IDX_CRC);
  assign crc_ok   = (data_byte == running_crc);

  always_comb begin
    priority if (byte_count != scfc_pkg::IDX_CRC) begin
      status = scfc_pkg::ST_BAD_LEN;
    end else if (!sync_match) begin
      status = scfc_pkg::ST_BAD_SYN;
    end else if (!crc_ok) begin
      status = scfc_pkg::ST_BAD_CRC;
    end else begin
      status = scfc_pkg::ST_OK;
    end
  end

  always_comb begin
    push              = accept && last_byte;
    push_job.status   = status;
    push_job.msg_type = (status == scfc_pkg::ST_OK) ? type_hold : 8'd0;
    push_job.seq      = (status == scfc_pkg::ST_OK) ? sequence_hold : 8'd0;
    push_job.bank     = wr_bank;
  end

  always_comb begin
    memwr.en   = accept && (byte_count >= scfc_pkg::IDX_PL0)
                 && (byte_count < scfc_pkg::IDX_CRC);
    memwr.bank = wr_bank;
    memwr.addr = scfc_pkg::IDX_W'(byte_count - scfc_pkg::IDX_PL0);
    memwr.data = data_byte;
  end

  always_ff @(posedge clk) begin
    if (accept && byte_count == scfc_pkg::IDX_TYPE) begin
      type_hold <= data_byte;
    end
    if (accept && byte_count == scfc_pkg::IDX_SEQ) begin
      sequence_hold <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= scfc_pkg::SYNC_FIRST_RST;
      sync_second <= scfc_pkg::SYNC_SECOND_RST;
      byte_count  <= '0;
      running_crc <= scfc_pkg::CRC_INIT;
      sync_match  <= 1'b1;
      wr_bank     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          scfc_pkg::REG_SYNC_FIRST:  sync_first  <= cfg_data;
          scfc_pkg::REG_SYNC_SECOND: sync_second <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (last_byte) begin
          byte_count  <= '0;
          running_crc <= scfc_pkg::CRC_INIT;
          sync_match  <= 1'b1;
          // a good frame keeps its bank until the back end drains it
          if (status == scfc_pkg::ST_OK) begin
            wr_bank <= !wr_bank;
          end
        end else begin
          if (byte_count != scfc_pkg::COUNT_MAX) begin
            byte_count <= byte_count + 7'd1;
          end
          if (byte_count == scfc_pkg::IDX_SYNC0 && data_byte != sync_first) begin
            sync_match <= 1'b0;
          end
          if (byte_count == scfc_pkg::IDX_SYNC1 && data_byte != sync_second) begin
            sync_match <= 1'b0;
          end
          if (in_body) begin
            running_crc <= scfc_pkg::crc8_byte(running_crc, data_byte);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/scfc_queue.sv
// Two-entry job queue between front and back end.
// Uses scfc_pkg::job_t.
`default_nettype none

module scfc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire scfc_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                head_valid,
  output scfc_pkg::job_t      head
);

  scfc_pkg::job_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/scfc_back.sv
// Back end: holds the two-bank payload store and turns each job into a status
// item, plus payload items for good jobs, via an output register. Uses scfc_pkg.
`default_nettype none

module scfc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire scfc_pkg::memwr_t memwr,
  input  wire logic             head_valid,
  input  wire scfc_pkg::job_t   head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  is_payload,
  output logic [1:0]            status,
  output logic [7:0]            message_type,
  output logic [7:0]            sequence_res,
  output logic [7:0]            payload_byte,
  output logic [4:0]            payload_index,
  output logic                  end_of_run
);

  typedef enum logic [1:0] {
    B_STATUS  = 2'b01,
    B_PAYLOAD = 2'b10
  } bstate_t;

  bstate_t                    state;
  bstate_t                    state_next;
  logic [scfc_pkg::IDX_W-1:0] pl_idx;
  logic [scfc_pkg::IDX_W-1:0] pl_idx_next;
  logic [7:0]                 pl_mem [2][scfc_pkg::PAYLOAD_BYTES];
  logic [7:0]                 rd_q;
  logic                       load;
  logic                       pl_last;
  logic                       job_ok;

  assign load    = head_valid && (!out_valid || !out_stall);
  assign pl_last = (pl_idx == scfc_pkg::PL_LAST);
  assign job_ok  = (head.status == scfc_pkg::ST_OK);

  always_comb begin
    state_next  = state;
    pl_idx_next = pl_idx;
    pop         = 1'b0;
    unique case (state)
      B_STATUS: begin
        pl_idx_next = '0;
        if (load) begin
          if (job_ok) begin
            state_next = B_PAYLOAD;
          end else begin
            pop = 1'b1;
          end
        end
      end
      B_PAYLOAD: begin
        if (load) begin
          if (pl_last) begin
            pop         = 1'b1;
            state_next  = B_STATUS;
            pl_idx_next = '0;
          end else begin
            pl_idx_next = pl_idx + scfc_pkg::IDX_W'(1);
          end
        end
      end
      default: begin
        state_next  = B_STATUS;
        pl_idx_next = '0;
      end
    endcase
  end

  // rd_q always holds the entry that the next payload item will need
  always_ff @(posedge clk) begin
    if (memwr.en) begin
      pl_mem[memwr.bank][memwr.addr] <= memwr.data;
    end
    rd_q <= pl_mem[head.bank][pl_idx_next];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unique case (state)
        B_PAYLOAD: begin
          is_payload    <= 1'b1;
          status        <= scfc_pkg::ST_OK;
          message_type  <= 8'd0;
          sequence_res  <= 8'd0;
          payload_byte  <= rd_q;
          payload_index <= 5'(pl_idx);
          end_of_run    <= pl_last;
        end
        default: begin
          is_payload    <= 1'b0;
          status        <= head.status;
          message_type  <= head.msg_type;
          sequence_res  <= head.seq;
          payload_byte  <= 8'd0;
          payload_index <= 5'd0;
          end_of_run    <= !job_ok;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_STATUS;
      pl_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      pl_idx <= pl_idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_payload_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_payload |-> status == scfc_pkg::ST_OK && message_type == 8'd0)
    else $error("payload item with status or type set");

  a_error_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_payload && status != scfc_pkg::ST_OK |-> end_of_run)
    else $error("failed frame status item without end of run");

  a_payload_has_job: assert property (@(posedge clk) disable iff (rst)
    state == B_PAYLOAD |-> head_valid)
    else $error("payload phase with no job queued");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    state == B_PAYLOAD && load && pl_last |=> state == B_STATUS)
    else $error("payload phase did not end after last byte");
`endif

endmodule

`default_nettype wire

### sv/sync_crc8_frame_checker.sv
// Sync/CRC-8 frame checker: takes one byte per cycle when not stalled (last
// byte flagged), checks length, then sync bytes, then CRC-8 (poly 0x07, init
// 0) over type, sequence and payload, and emits a status transaction, followed
// for a good frame by one transaction per payload byte. Input and output each
// move one transaction per cycle when not stalled; a good frame of
// PAYLOAD_BYTES+5 input bytes yields PAYLOAD_BYTES+1 results, so the output
// keeps pace. Between the front end and the result sequencer sit a two-entry
// job queue and a two-bank payload store: the input stalls only while two
// checked frames still wait to drain.
// Uses scfc_pkg, scfc_front, scfc_queue and scfc_back.
`default_nettype none

module sync_crc8_frame_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            is_payload,
  output logic [1:0]      status,
  output logic [7:0]      message_type,
  output logic [7:0]      sequence_res,
  output logic [7:0]      payload_byte,
  output logic [4:0]      payload_index,
  output logic            end_of_run
);

  logic              q_full;
  logic              push;
  logic              pop;
  logic              head_valid;
  scfc_pkg::job_t    push_job;
  scfc_pkg::job_t    head;
  scfc_pkg::memwr_t  memwr;

  scfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job),
    .memwr     (memwr)
  );

  scfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  scfc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .memwr         (memwr),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_payload    (is_payload),
    .status        (status),
    .message_type  (message_type),
    .sequence_res  (sequence_res),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .end_of_run    (end_of_run)
  );

endmodule

`default_nettype wire
